@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros used by ordered_timer_queue
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

@@ design/otq_pkg.sv @@
// ---------------------------------------------------------------------------
// otq_pkg
// types, codes and constants of the ordered timer queue
// ---------------------------------------------------------------------------
package otq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int EXP_W        = 48;
    localparam int ID_W         = 32;
    localparam int DUR_W        = 32;
    localparam int CNT_OUT_W    = 5;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_DEL   = 2'd2;
    localparam logic [1:0] OP_CHECK = 2'd3;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam logic [EXP_W-1:0] TIME_MAX = '1;

    // expiry in the upper bits, so a plain compare orders by expiry then id
    typedef struct packed {
        logic [EXP_W-1:0] expire;
        logic [ID_W-1:0]  id;
    } key_t;

    typedef struct packed {
        logic valid;
        key_t key;
    } cell_t;

    // broadcast to every cell for one update
    typedef struct packed {
        logic ins;
        logic rem;
        logic pop;
    } cmd_t;

    function automatic logic key_before(input key_t a, input key_t b);
        return a < b;
    endfunction

endpackage

@@ design/otq_cell.sv @@
// ---------------------------------------------------------------------------
// otq_cell
// one slot of the sorted timer row; shifts right on insert, left on remove
// ---------------------------------------------------------------------------
module otq_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  otq_pkg::key_t  key,
    input  otq_pkg::cmd_t  cmd,
    input  otq_pkg::cell_t left,
    input  logic           left_ins,
    input  otq_pkg::cell_t right,
    output otq_pkg::cell_t cur,
    output otq_pkg::cell_t nxt,
    output logic           ins_here,
    output logic           match
);
    import otq_pkg::*;

    logic valid_reg;
    key_t key_reg;
    logic at_or_after;

    assign cur.valid = valid_reg;
    assign cur.key   = key_reg;

    assign ins_here    = !valid_reg || key_before(key, key_reg);
    assign at_or_after = valid_reg && !key_before(key_reg, key);
    assign match       = valid_reg && (key_reg == key);

    always_comb
    begin
        nxt = cur;
        if (cmd.ins && ins_here)
        begin
            if (left_ins)
                nxt = left;
            else
            begin
                nxt.valid = 1'b1;
                nxt.key   = key;
            end
        end
        else if ((cmd.rem && at_or_after) || cmd.pop)
        begin
            nxt = right;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= nxt.valid;
    end

    always_ff @(posedge clk)
    begin
        key_reg <= nxt.key;
    end

endmodule

@@ design/ordered_timer_queue.sv @@
// ---------------------------------------------------------------------------
// ordered_timer_queue: an accepted word is captured and its key built, then
// one shift of the sorted cell row registers the result word; no new word is
// taken until that shift; a stalled result holds the row until it leaves
// reset clears all cell valid bits, the time counter, the id counter and count
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ordered_timer_queue #(
    parameter int CAPACITY = otq_pkg::CAPACITY_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // duration[31:0], del_expire[79:32], del_id[111:80]
    input  logic [1:0]   s_tuser,   // operation[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // timer_id[31:0], expire_time[79:32],
                                    // sleep_time[127:80], queue_empty[128],
                                    // pending_count[133:129], zero[135:134]
    output logic [1:0]   m_tuser    // status[1:0]
);
    import otq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic             state_reg, state_next;
    logic [1:0]       op_reg;
    key_t             key_reg;
    logic [EXP_W-1:0] now_reg, now_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [CW-1:0]    count_reg, count_next;

    logic             m_tvalid_reg;
    logic [1:0]       status_reg;
    logic [ID_W-1:0]  rid_reg;
    logic [EXP_W-1:0] rexp_reg;
    logic [EXP_W-1:0] sleep_reg;
    logic             empty_reg;
    logic [CNT_OUT_W-1:0] pcount_reg;

    cell_t            cur   [CAPACITY];
    cell_t            nxt   [CAPACITY];
    logic             ins_v [CAPACITY];
    logic [CAPACITY-1:0] match_vec;
    logic [CAPACITY-1:0] valid_vec;

    cmd_t             cmd;
    logic             accept, out_free, go;
    logic             full, found, due;
    logic [EXP_W:0]   add_sum;
    key_t             key_in;

    logic [1:0]       status_c;
    logic [ID_W-1:0]  rid_c;
    logic [EXP_W-1:0] rexp_c;
    logic [EXP_W-1:0] sleep_c;
    logic [CW+CNT_OUT_W-1:0] count_ext;

    // ---------------- cell row ----------------
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            cell_t left_c, right_c;
            logic  left_ins_c;
            if (gi == 0)
            begin : g_first
                assign left_c     = '{valid: 1'b0, key: key_reg};
                assign left_ins_c = 1'b0;
            end
            else
            begin : g_mid
                assign left_c     = cur[gi-1];
                assign left_ins_c = ins_v[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_c = '{valid: 1'b0, key: key_reg};
            end
            else
            begin : g_inner
                assign right_c = cur[gi+1];
            end

            otq_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .key      (key_reg),
                .cmd      (cmd),
                .left     (left_c),
                .left_ins (left_ins_c),
                .right    (right_c),
                .cur      (cur[gi]),
                .nxt      (nxt[gi]),
                .ins_here (ins_v[gi]),
                .match    (match_vec[gi])
            );
            assign valid_vec[gi] = cur[gi].valid;
        end
    endgenerate

    // ---------------- capture ----------------
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // add expiry saturates at the top of the time counter
    assign add_sum = {1'b0, now_reg} + (EXP_W + 1)'(s_tdata[DUR_W-1:0]);

    always_comb
    begin
        if (s_tuser == OP_ADD)
        begin
            key_in.expire = add_sum[EXP_W] ? TIME_MAX : add_sum[EXP_W-1:0];
            key_in.id     = id_reg + ID_W'(1);
        end
        else
        begin
            key_in.expire = s_tdata[DUR_W +: EXP_W];
            key_in.id     = s_tdata[DUR_W+EXP_W +: ID_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= s_tuser;
            key_reg <= key_in;
        end
    end

    // ---------------- execute ----------------
    assign out_free = !m_tvalid_reg || m_tready;
    assign go       = (state_reg == ST_EXEC) && out_free;

    assign full  = (count_reg == CW'(CAPACITY));
    assign found = |match_vec;
    assign due   = cur[0].valid && (cur[0].key.expire <= now_reg);

    always_comb
    begin
        cmd.ins = go && (op_reg == OP_ADD) && !full && !found;
        cmd.rem = go && (op_reg == OP_DEL) && found;
        cmd.pop = go && (op_reg == OP_CHECK) && due;
    end

    always_comb
    begin
        now_next   = now_reg;
        id_next    = id_reg;
        count_next = count_reg;
        status_c   = STATUS_OK;
        rid_c      = '0;
        rexp_c     = '0;
        unique case (op_reg)
            OP_TICK:
            begin
                if (now_reg != TIME_MAX)
                    now_next = now_reg + EXP_W'(1);
            end
            OP_ADD:
            begin
                if (full)
                    status_c = STATUS_FULL;
                else
                begin
                    id_next = key_reg.id;
                    rid_c   = key_reg.id;
                    rexp_c  = key_reg.expire;
                    if (!found)
                        count_next = count_reg + CW'(1);
                end
            end
            OP_DEL:
            begin
                if (found)
                begin
                    rid_c      = key_reg.id;
                    rexp_c     = key_reg.expire;
                    count_next = count_reg - CW'(1);
                end
                else
                    status_c = STATUS_MISS;
            end
            OP_CHECK:
            begin
                if (due)
                begin
                    rid_c      = cur[0].key.id;
                    rexp_c     = cur[0].key.expire;
                    count_next = count_reg - CW'(1);
                end
                else
                    status_c = STATUS_MISS;
            end
            default:
            begin
                status_c = STATUS_MISS;
            end
        endcase
    end

    // sleep comes from the head after this update
    always_comb
    begin
        if (nxt[0].valid && (nxt[0].key.expire > now_next))
            sleep_c = nxt[0].key.expire - now_next;
        else
            sleep_c = '0;
    end

    assign count_ext = (CW + CNT_OUT_W)'(count_next);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_EXEC;
            ST_EXEC: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            now_reg      <= '0;
            id_reg       <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (go)
            begin
                now_reg      <= now_next;
                id_reg       <= id_next;
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            status_reg <= status_c;
            rid_reg    <= rid_c;
            rexp_reg   <= rexp_c;
            sleep_reg  <= sleep_c;
            empty_reg  <= !nxt[0].valid;
            pcount_reg <= count_ext[CNT_OUT_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {2'b00, pcount_reg, empty_reg, sleep_reg, rexp_reg, rid_reg};

    // ---------------- checks ----------------
    `ASSERT_ALWAYS(a_count_tracks_cells, clk, rst_n, count_reg == CW'($countones(valid_vec)))
    `ASSERT_ALWAYS(a_cells_packed, clk, rst_n, ((valid_vec + CAPACITY'(1)) & valid_vec) == '0)
    `ASSERT_IMPLIES(a_head_ordered, clk, rst_n, cur[0].valid && cur[1].valid, cur[0].key < cur[1].key)
    `ASSERT_IMPLIES(a_result_after_exec, clk, rst_n, $rose(m_tvalid_reg), $past(state_reg) == ST_EXEC)

endmodule
